// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the spline evaluator.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/ccsb_pkg.sv =====
// ---------------------------------------------------------------------------
// ccsb_pkg
// Shared types and constants of the cubic spline basis evaluator.
// ---------------------------------------------------------------------------
package ccsb_pkg;

    localparam int MAX_SPANS_DEF = 64;
    localparam int MAX_BINS_DEF  = 256;
    localparam int QUEUE_DEPTH   = 4;
    localparam int SPW           = 6;   // span / basis index width
    localparam int IDXW          = 10;  // store address width on the input beat

    // item modes
    typedef enum logic [2:0] {
        MODE_EVAL = 3'd0,
        MODE_KNOT = 3'd1,
        MODE_COEF = 3'd2,
        MODE_INVW = 3'd3,
        MODE_BIN  = 3'd4
    } t_mode;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_RANGE_LOW  = 3'd0,
        REG_RANGE_HIGH = 3'd1,
        REG_BIN_SCALE  = 3'd2,
        REG_LAST_SPAN  = 3'd3,
        REG_BINS_USED  = 3'd4
    } t_reg;

    typedef struct packed {
        logic signed [31:0] range_low;
        logic signed [31:0] range_high;
        logic        [31:0] bin_scale;
        logic        [5:0]  last_span;
        logic        [8:0]  bins_in_use;
    } t_cfg;

    // one queue entry: a coefficient write or a located evaluation
    typedef struct packed {
        logic               is_write;
        logic [IDXW-1:0]    waddr;
        logic [31:0]        wdata;
        logic [SPW-1:0]     span;
        logic signed [32:0] diff;   // x - knot[span], Q9.24
        logic signed [31:0] inv;    // inverse span width, Q16.16
    } t_job;

endpackage

// ===== sv/ccsb_if.sv =====
// ---------------------------------------------------------------------------
// ccsb_if
// Valid/ready channel interfaces for input items and result beats.
// ---------------------------------------------------------------------------
interface ccsb_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         mode;
    logic signed [31:0] x;
    logic [9:0]         table_index;
    logic signed [31:0] write_value;

    modport source (output valid, mode, x, table_index, write_value, input ready);
    modport sink   (input valid, mode, x, table_index, write_value, output ready);
endinterface

interface ccsb_rsp_if;
    logic               valid;
    logic               ready;
    logic [5:0]         basis_index;
    logic signed [31:0] basis_value;
    logic signed [47:0] first_derivative;
    logic signed [47:0] second_derivative;
    logic               last;

    modport source (output valid, basis_index, basis_value, first_derivative,
                    second_derivative, last, input ready);
    modport sink   (input valid, basis_index, basis_value, first_derivative,
                    second_derivative, last, output ready);
endinterface

// ===== sv/cached_cubic_spline_basis_eval_core.sv =====
// ---------------------------------------------------------------------------
// cached_cubic_spline_basis_eval_core
// Cubic B-spline basis, first and second derivative evaluator with span lookup.
// ---------------------------------------------------------------------------
// Load the knot, inverse-width, bin and coefficient stores with write items
// (modes 1..4) and set the range registers over APB, then send evaluation
// items (mode 0): each returns four result beats, the fourth marked last.
// The front locates an evaluation by clamp, bin lookup, span walk and knot
// fetch, and hands it through a 4-entry queue to the back. The back runs
// every product through one shared 25x32 multiplier (two partial products,
// then recombine and saturate): it dequeues, computes the normalized
// abscissa, then per basis function fetches the coefficients, does the
// arithmetic and loads the output register.
// The front locates the next evaluation while the back is busy. Stores hold
// garbage until written.
module cached_cubic_spline_basis_eval_core import ccsb_pkg::*; #(
    parameter int MAX_SPANS = MAX_SPANS_DEF,
    parameter int MAX_BINS  = MAX_BINS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ccsb_req_if.sink    i_req,
    ccsb_rsp_if.source  o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    t_cfg r_cfg;
    t_reg w_reg;
    logic w_cfg_we;
    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_qvalid;
    t_job w_fjob;
    t_job w_qjob;

    assign pready   = 1'b1;
    assign w_reg    = t_reg'(paddr[4:2]);
    assign w_cfg_we = psel && penable && pwrite && pready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.range_low   <= 32'sd0;
            r_cfg.range_high  <= 32'sd16777216;
            r_cfg.bin_scale   <= 32'd65536;
            r_cfg.last_span   <= 6'd3;
            r_cfg.bins_in_use <= 9'd256;
        end else if (w_cfg_we) begin
            case (w_reg)
                REG_RANGE_LOW:  r_cfg.range_low   <= $signed(pwdata);
                REG_RANGE_HIGH: r_cfg.range_high  <= $signed(pwdata);
                REG_BIN_SCALE:  r_cfg.bin_scale   <= pwdata;
                REG_LAST_SPAN:  r_cfg.last_span   <= pwdata[5:0];
                REG_BINS_USED:  r_cfg.bins_in_use <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    // register read-back
    always_comb begin
        case (w_reg)
            REG_RANGE_LOW:  prdata = r_cfg.range_low;
            REG_RANGE_HIGH: prdata = r_cfg.range_high;
            REG_BIN_SCALE:  prdata = r_cfg.bin_scale;
            REG_LAST_SPAN:  prdata = {26'd0, r_cfg.last_span};
            REG_BINS_USED:  prdata = {23'd0, r_cfg.bins_in_use};
            default:        prdata = '0;
        endcase
    end

    ccsb_front #(.MAX_SPANS(MAX_SPANS), .MAX_BINS(MAX_BINS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg), .i_req(i_req),
        .o_push(w_push), .o_job(w_fjob), .i_full(w_full)
    );

    ccsb_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_push), .i_job(w_fjob),
        .i_pop(w_pop), .o_job(w_qjob), .o_full(w_full), .o_valid(w_qvalid)
    );

    ccsb_back #(.MAX_SPANS(MAX_SPANS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_job(w_qjob), .i_valid(w_qvalid),
        .o_pop(w_pop), .o_rsp(o_rsp)
    );
endmodule

// ===== sv/ccsb_ram.sv =====
// ---------------------------------------------------------------------------
// ccsb_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module ccsb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== sv/ccsb_front.sv =====
// ---------------------------------------------------------------------------
// ccsb_front
// Input side: store writes, clamp, bin lookup and span walk, knot fetch.
// ---------------------------------------------------------------------------
module ccsb_front import ccsb_pkg::*; #(
    parameter int MAX_SPANS = MAX_SPANS_DEF,
    parameter int MAX_BINS  = MAX_BINS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    ccsb_req_if.sink    i_req,
    output logic        o_push,
    output t_job        o_job,
    input  logic        i_full
);
`include "assert_macros.svh"

    localparam int SAW  = $clog2(MAX_SPANS);
    localparam int BAW  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int NMAX = MAX_SPANS - 2;

    typedef enum logic [3:0] {
        S_IDLE, S_CLAMP, S_BINA, S_BINR, S_WALK, S_WALKR, S_KNOT, S_KNOTR
    } t_state;

    t_state             r_state;
    logic signed [31:0] r_x;
    logic [SPW-1:0]     r_span;
    logic [63:0]        r_prod;

    logic               w_acc;
    logic [SPW-1:0]     w_n;
    logic signed [31:0] w_xc;
    logic signed [32:0] w_sdiff;
    logic [63:0]        w_bprod;
    logic [12:0]        w_bins;
    logic [23:0]        w_bsel;
    logic [SPW-1:0]     w_bsp;
    logic [SAW-1:0]     w_kaddr;
    logic [31:0]        w_knot;
    logic [31:0]        w_invw;
    logic [5:0]         w_binsp;

    assign i_req.ready = (r_state == S_IDLE) && !i_full;
    assign w_acc       = i_req.valid && i_req.ready;

    // last span clamped into 3 .. MAX_SPANS-2
    always_comb begin
        w_n = i_cfg.last_span;
        if (w_n < SPW'(3)) w_n = SPW'(3);
        if (32'(w_n) > NMAX) w_n = SPW'(NMAX);
    end

    // clamp to range; inverted range lets range_high win
    always_comb begin
        w_xc = r_x;
        if (w_xc < i_cfg.range_low)  w_xc = i_cfg.range_low;
        if (w_xc > i_cfg.range_high) w_xc = i_cfg.range_high;
    end
    assign w_sdiff = 33'(w_xc) - 33'(i_cfg.range_low);
    assign w_bprod = w_sdiff[31:0] * i_cfg.bin_scale;

    // bin index saturated to last bin in use
    always_comb begin
        w_bins = {4'd0, i_cfg.bins_in_use};
        if (w_bins == 13'd0) w_bins = 13'd1;
        if (32'(w_bins) > MAX_BINS) w_bins = 13'(MAX_BINS);
        w_bsel = r_prod[63:40];
        if (w_bsel >= 24'(w_bins)) w_bsel = 24'(w_bins - 13'd1);
    end

    // table span clamped into 3 .. last span
    always_comb begin
        w_bsp = w_binsp;
        if (w_bsp < SPW'(3)) w_bsp = SPW'(3);
        if (w_bsp > w_n) w_bsp = w_n;
    end

    assign w_kaddr = (r_state == S_WALK) ? SAW'(r_span + SPW'(1)) : SAW'(r_span);

    // stores owned by the front
    ccsb_ram #(.WIDTH(32), .DEPTH(MAX_SPANS)) u_knot (
        .i_clk(i_clk),
        .i_we(w_acc && i_req.mode == MODE_KNOT && 32'(i_req.table_index) < MAX_SPANS),
        .i_waddr(SAW'(i_req.table_index)), .i_wdata(i_req.write_value),
        .i_raddr(w_kaddr), .o_rdata(w_knot)
    );
    ccsb_ram #(.WIDTH(32), .DEPTH(MAX_SPANS)) u_invw (
        .i_clk(i_clk),
        .i_we(w_acc && i_req.mode == MODE_INVW && 32'(i_req.table_index) < MAX_SPANS),
        .i_waddr(SAW'(i_req.table_index)), .i_wdata(i_req.write_value),
        .i_raddr(SAW'(r_span)), .o_rdata(w_invw)
    );
    ccsb_ram #(.WIDTH(6), .DEPTH(MAX_BINS)) u_bin (
        .i_clk(i_clk),
        .i_we(w_acc && i_req.mode == MODE_BIN && 32'(i_req.table_index) < MAX_BINS),
        .i_waddr(BAW'(i_req.table_index)), .i_wdata(i_req.write_value[5:0]),
        .i_raddr(BAW'(w_bsel)), .o_rdata(w_binsp)
    );

    // queue push: coefficient writes on accept, evaluations once located
    always_comb begin
        o_job          = '0;
        o_push         = 1'b0;
        o_job.waddr    = i_req.table_index;
        o_job.wdata    = i_req.write_value;
        o_job.span     = r_span;
        o_job.diff     = 33'(r_x) - 33'($signed(w_knot));
        o_job.inv      = $signed(w_invw);
        if (w_acc && i_req.mode == MODE_COEF) begin
            o_job.is_write = 1'b1;
            o_push         = 1'b1;
        end else if (r_state == S_KNOTR && !i_full) begin
            o_push = 1'b1;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_acc && i_req.mode == MODE_EVAL) begin
                        r_x     <= i_req.x;
                        r_state <= S_CLAMP;
                    end
                end
                S_CLAMP: begin
                    r_x <= w_xc;
                    if (w_xc <= i_cfg.range_low) begin
                        r_span  <= SPW'(3);
                        r_state <= S_KNOT;
                    end else if (w_xc >= i_cfg.range_high) begin
                        r_span  <= w_n;
                        r_state <= S_KNOT;
                    end else begin
                        r_prod  <= w_bprod;
                        r_state <= S_BINA;
                    end
                end
                S_BINA: r_state <= S_BINR;
                S_BINR: begin
                    r_span  <= w_bsp;
                    r_state <= S_WALK;
                end
                S_WALK: r_state <= (r_span < w_n) ? S_WALKR : S_KNOT;
                S_WALKR: begin
                    if (r_x >= $signed(w_knot)) begin
                        r_span  <= r_span + SPW'(1);
                        r_state <= S_WALK;
                    end else begin
                        r_state <= S_KNOT;
                    end
                end
                S_KNOT: r_state <= S_KNOTR;
                S_KNOTR: begin
                    if (!i_full) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // located spans always lie in 3 .. last span
    `ASSERT_IMPL(a_span_range, i_clk, i_rst_n, o_push && !o_job.is_write, (o_job.span >= SPW'(3)) && (o_job.span <= w_n))
endmodule

// ===== sv/ccsb_queue.sv =====
// ---------------------------------------------------------------------------
// ccsb_queue
// Small FIFO of jobs between the front and the back.
// ---------------------------------------------------------------------------
module ccsb_queue import ccsb_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_full,
    output logic o_valid
);
`include "assert_macros.svh"

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_slot [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wr] <= i_job;
    end

    // pointers wrap at DEPTH
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= (32'(r_wr) == DEPTH - 1) ? '0 : r_wr + PW'(1);
            if (i_pop)  r_rd <= (32'(r_rd) == DEPTH - 1) ? '0 : r_rd + PW'(1);
            if (i_push && !i_pop) r_count <= r_count + CW'(1);
            else if (i_pop && !i_push) r_count <= r_count - CW'(1);
        end
    end

    `ASSERT_IMPL(a_no_overrun, i_clk, i_rst_n, o_full, !i_push || i_pop)
    `ASSERT_IMPL(a_no_underrun, i_clk, i_rst_n, !o_valid, !i_pop)
endmodule

// ===== sv/ccsb_back.sv =====
// ---------------------------------------------------------------------------
// ccsb_back
// Execution side: coefficient store and shared multiply-shift-saturate unit
// that runs the Horner and derivative steps and emits four result beats.
// ---------------------------------------------------------------------------
module ccsb_back import ccsb_pkg::*; #(
    parameter int MAX_SPANS = MAX_SPANS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_job       i_job,
    input  logic       i_valid,
    output logic       o_pop,
    ccsb_rsp_if.source o_rsp
);
`include "assert_macros.svh"

    localparam int SAW = $clog2(MAX_SPANS);
    localparam int CAW = SAW + 4;
    localparam logic signed [80:0] MAX32 = 81'sd2147483647;
    localparam logic signed [80:0] MIN32 = -81'sd2147483648;
    localparam logic signed [80:0] MAX48 = 81'sd140737488355327;
    localparam logic signed [80:0] MIN48 = -81'sd140737488355328;

    typedef enum logic [2:0] {S_IDLE, S_LOAD, S_CALC, S_EMIT} t_state;
    typedef enum logic [3:0] {
        OP_XI, OP_V3, OP_V2, OP_V1, OP_T1, OP_T2, OP_D1, OP_U1, OP_Q, OP_D2
    } t_op;

    function automatic logic signed [31:0] f_sat32(input logic signed [80:0] v);
        if (v > MAX32) return MAX32[31:0];
        if (v < MIN32) return MIN32[31:0];
        return v[31:0];
    endfunction

    function automatic logic signed [47:0] f_sat48(input logic signed [80:0] v);
        if (v > MAX48) return MAX48[47:0];
        if (v < MIN48) return MIN48[47:0];
        return v[47:0];
    endfunction

    t_state             r_state;
    t_op                r_op;
    logic [1:0]         r_ph;
    logic [1:0]         r_basis;
    logic [2:0]         r_k;
    logic [SPW-1:0]     r_span;
    logic signed [32:0] r_diff;
    logic signed [31:0] r_inv;
    logic signed [31:0] r_xi;
    logic signed [31:0] r_a [4];
    logic signed [31:0] r_v;
    logic signed [31:0] r_t;
    logic signed [47:0] r_d1;
    logic signed [47:0] r_q;
    logic signed [47:0] r_d2;
    logic signed [56:0] r_plo;
    logic signed [56:0] r_phi;
    logic               r_ov;
    logic [5:0]         r_o_idx;
    logic signed [31:0] r_o_val;
    logic signed [47:0] r_o_d1;
    logic signed [47:0] r_o_d2;
    logic               r_o_last;

    logic signed [47:0] w_a;
    logic signed [31:0] w_b;
    logic               w_sh16;
    logic               w_w48;
    logic signed [33:0] w_add;
    logic               w_has_add;
    logic signed [47:0] w_a3x3;
    logic signed [33:0] w_a2x2;
    logic signed [24:0] w_mop;
    logic signed [56:0] w_prod;
    logic signed [80:0] w_full;
    logic signed [80:0] w_shr;
    logic signed [47:0] w_ms;
    logic signed [47:0] w_res;
    logic               w_cwe;
    logic               w_load;
    logic [31:0]        w_coef;

    // coefficient store, written in order through the queue
    assign o_pop = (r_state == S_IDLE) && i_valid;
    assign w_cwe = o_pop && i_job.is_write && 32'(i_job.waddr) < MAX_SPANS * 16;

    ccsb_ram #(.WIDTH(32), .DEPTH(MAX_SPANS * 16)) u_coef (
        .i_clk(i_clk), .i_we(w_cwe), .i_waddr(CAW'(i_job.waddr)), .i_wdata(i_job.wdata),
        .i_raddr({SAW'(r_span), r_basis, r_k[1:0]}), .o_rdata(w_coef)
    );

    // operand selection per step
    assign w_a3x3 = (48'(r_a[3]) <<< 1) + 48'(r_a[3]);
    assign w_a2x2 = 34'(r_a[2]) <<< 1;

    always_comb begin
        w_a       = 48'(r_v);
        w_b       = r_xi;
        w_sh16    = 1'b0;
        w_w48     = 1'b0;
        w_add     = '0;
        w_has_add = 1'b0;
        case (r_op)
            OP_XI: begin w_a = 48'(r_diff); w_b = r_inv; w_sh16 = 1'b1; end
            OP_V3: begin w_a = 48'(r_a[3]); w_add = 34'(r_a[2]); w_has_add = 1'b1; end
            OP_V2: begin w_add = 34'(r_a[1]); w_has_add = 1'b1; end
            OP_V1: begin w_add = 34'(r_a[0]); w_has_add = 1'b1; end
            OP_T1: begin w_a = w_a3x3; w_add = w_a2x2; w_has_add = 1'b1; end
            OP_T2: begin w_a = 48'(r_t); w_add = 34'(r_a[1]); w_has_add = 1'b1; end
            OP_D1: begin w_a = 48'(r_t); w_b = r_inv; w_sh16 = 1'b1; w_w48 = 1'b1; end
            OP_U1: begin w_a = w_a3x3 <<< 1; w_add = w_a2x2; w_has_add = 1'b1; end
            OP_Q:  begin w_a = 48'(r_t); w_b = r_inv; w_sh16 = 1'b1; w_w48 = 1'b1; end
            OP_D2: begin w_a = r_q; w_b = r_inv; w_sh16 = 1'b1; w_w48 = 1'b1; end
            default: ;
        endcase
    end

    // one 25x32 multiplier: low 24 bits of A in phase 0, high part in phase 1
    assign w_mop  = (r_ph == 2'd0) ? $signed({1'b0, w_a[23:0]}) : $signed({w_a[47], w_a[47:24]});
    assign w_prod = w_mop * w_b;

    // phase 2: recombine, floor shift, saturate, optional add
    assign w_full = (81'(r_phi) <<< 24) + 81'(r_plo);
    assign w_shr  = w_sh16 ? (w_full >>> 16) : (w_full >>> 24);
    assign w_ms   = w_w48 ? f_sat48(w_shr) : 48'(f_sat32(w_shr));
    assign w_res  = w_has_add ? 48'(f_sat32(81'(w_ms) + 81'(w_add))) : w_ms;

    assign w_load = (r_state == S_EMIT) && (!r_ov || o_rsp.ready);

    // output register
    assign o_rsp.valid             = r_ov;
    assign o_rsp.basis_index       = r_o_idx;
    assign o_rsp.basis_value       = r_o_val;
    assign o_rsp.first_derivative  = r_o_d1;
    assign o_rsp.second_derivative = r_o_d2;
    assign o_rsp.last              = r_o_last;

    // sequencer and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_op    <= OP_XI;
            r_ph    <= 2'd0;
            r_basis <= 2'd0;
            r_k     <= 3'd0;
        end else begin
            if (w_load) r_ov <= 1'b1;
            else if (o_rsp.ready) r_ov <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    if (o_pop && !i_job.is_write) begin
                        r_span  <= i_job.span;
                        r_diff  <= i_job.diff;
                        r_inv   <= i_job.inv;
                        r_basis <= 2'd0;
                        r_op    <= OP_XI;
                        r_ph    <= 2'd0;
                        r_state <= S_CALC;
                    end
                end
                S_LOAD: begin
                    if (r_k != 3'd0) r_a[2'(r_k - 3'd1)] <= $signed(w_coef);
                    if (r_k == 3'd4) begin
                        r_op    <= OP_V3;
                        r_ph    <= 2'd0;
                        r_state <= S_CALC;
                    end else begin
                        r_k <= r_k + 3'd1;
                    end
                end
                S_CALC: begin
                    case (r_ph)
                        2'd0: begin r_plo <= w_prod; r_ph <= 2'd1; end
                        2'd1: begin r_phi <= w_prod; r_ph <= 2'd2; end
                        default: begin
                            r_ph <= 2'd0;
                            case (r_op)
                                OP_XI: r_xi <= 32'(w_res);
                                OP_V3, OP_V2, OP_V1: r_v <= 32'(w_res);
                                OP_T1, OP_T2, OP_U1: r_t <= 32'(w_res);
                                OP_D1: r_d1 <= w_res;
                                OP_Q:  r_q  <= w_res;
                                OP_D2: r_d2 <= w_res;
                                default: ;
                            endcase
                            if (r_op == OP_XI) begin
                                r_k     <= 3'd0;
                                r_state <= S_LOAD;
                            end else if (r_op == OP_D2) begin
                                r_state <= S_EMIT;
                            end else begin
                                r_op <= t_op'(r_op + 4'd1);
                            end
                        end
                    endcase
                end
                S_EMIT: begin
                    if (w_load) begin
                        r_o_idx  <= r_span - 6'd3 + 6'(r_basis);
                        r_o_val  <= r_v;
                        r_o_d1   <= r_d1;
                        r_o_d2   <= r_d2;
                        r_o_last <= (r_basis == 2'd3);
                        if (r_basis == 2'd3) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_basis <= r_basis + 2'd1;
                            r_k     <= 3'd0;
                            r_state <= S_LOAD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // coefficient writes never land while an evaluation is in flight
    `ASSERT_IMPL(a_cwe_idle, i_clk, i_rst_n, w_cwe, r_state == S_IDLE)
    `ASSERT_IMPL(a_phase_ok, i_clk, i_rst_n, r_state == S_CALC, r_ph != 2'd3)
    // a last beat returns the back to idle
    `ASSERT_NEXT(a_last_idle, i_clk, i_rst_n, w_load && r_basis == 2'd3, r_state == S_IDLE)
endmodule
